FILE: src/b64d_pkg.sv
// Shared types, constants and functions of the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

  localparam int COUNT_BITS = 24;
  localparam int COUNT_FIELD_W = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int TDATA_IN_W = 8;
  localparam int TDATA_OUT_W = 40;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic                     is_status;
    logic                     status;
    logic [1:0]               nbytes;
    logic [COUNT_FIELD_W-1:0] word;
  } b64d_cmd_t;

  typedef struct packed {
    logic      push;
    b64d_cmd_t cmd;
  } b64d_push_t;

  typedef struct packed {
    logic      valid;
    b64d_cmd_t cmd;
  } b64d_head_t;

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 7'd62;
    end else if (c == 8'h2F) begin
      s = 7'd63;
    end
    return s;
  endfunction

  function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [COUNT_BITS-1:0] t);
    logic [31:0] w;
    w = 32'(t);
    return w[COUNT_FIELD_W-1:0];
  endfunction

endpackage

FILE: src/base64_stream_decoder.sv
// Top level of the base64 stream decoder.
// Path: a character or terminator transfer goes from the front into the command queue,
// then from the queue into the output register, which presents the result transfer.
// Throughput: one input transfer per cycle while the four-entry command queue has room;
// one result transfer per cycle at the output register while m_tready is held, up to three per group.
// Reset (rst, synchronous): clears group state, byte count, queue and output valid.
`timescale 1ns / 1ps
module base64_stream_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [b64d_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] ch
  input  logic                                s_tlast,   // is_end
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [b64d_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [7:0] out_byte, [8] status,
                                                         // [32:9] byte_count, [39:33] zero
  output logic                                m_tuser,   // kind
  output logic                                m_tlast    // run_last
);

  b64d_pkg::b64d_push_t push;
  b64d_pkg::b64d_head_t head;
  logic                 full;
  logic                 pop;
  logic                 in_fire;

  assign s_tready = !full;
  assign in_fire = s_tvalid && s_tready;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .ch       (s_tdata),
    .is_end   (s_tlast),
    .push_out (push)
  );

  b64d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_in (push),
    .pop     (pop),
    .full    (full),
    .head    (head)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: src/b64d_front.sv
// Front part: accepts characters, tracks group state and issues decode commands.
`timescale 1ns / 1ps
module b64d_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic [7:0]             ch,
  input  logic                   is_end,
  output b64d_pkg::b64d_push_t   push_out
);

  logic [17:0]                     group_bits, group_bits_next;
  logic [1:0]                      group_pos, group_pos_next;
  logic                            pad_seen, pad_seen_next;
  logic                            stopped, stopped_next;
  logic                            failed, failed_next;
  logic [b64d_pkg::COUNT_BITS-1:0] total, total_next;
  logic [b64d_pkg::COUNT_BITS:0]   sum;
  logic [6:0]                      sx;
  logic                            sx_ok;
  logic                            is_pad;
  logic [1:0]                      nb;
  b64d_pkg::b64d_push_t            push_next;

  always_comb begin
    sx = b64d_pkg::sextet_of(ch);
    sx_ok = !sx[6];
    is_pad = (ch == b64d_pkg::PAD_CHAR);
    group_bits_next = group_bits;
    group_pos_next = group_pos;
    pad_seen_next = pad_seen;
    stopped_next = stopped;
    failed_next = failed;
    total_next = total;
    nb = 2'd3;
    sum = '0;
    push_next = '0;
    if (in_fire) begin
      if (is_end) begin
        push_next.push = 1'b1;
        push_next.cmd.is_status = b64d_pkg::KIND_STATUS;
        push_next.cmd.status = (failed || group_pos != 2'd0) ? b64d_pkg::STATUS_ERROR
                                                              : b64d_pkg::STATUS_OK;
        push_next.cmd.word = b64d_pkg::count_field(total);
        group_bits_next = '0;
        group_pos_next = '0;
        pad_seen_next = 1'b0;
        stopped_next = 1'b0;
        failed_next = 1'b0;
        total_next = '0;
      end else if (!stopped && !failed) begin
        case (group_pos)
          2'd0: begin
            if (sx_ok) begin
              group_bits_next = {12'd0, sx[5:0]};
              pad_seen_next = 1'b0;
              group_pos_next = 2'd1;
            end else if (is_pad) begin
              failed_next = 1'b1;
            end else begin
              stopped_next = 1'b1;
            end
          end
          2'd1: begin
            if (sx_ok) begin
              group_bits_next = {group_bits[11:0], sx[5:0]};
              group_pos_next = 2'd2;
            end else begin
              failed_next = 1'b1;
            end
          end
          2'd2: begin
            if (is_pad) begin
              pad_seen_next = 1'b1;
              group_bits_next = {group_bits[11:0], 6'd0};
              group_pos_next = 2'd3;
            end else if (sx_ok) begin
              group_bits_next = {group_bits[11:0], sx[5:0]};
              group_pos_next = 2'd3;
            end else begin
              failed_next = 1'b1;
            end
          end
          default: begin
            if (is_pad || (sx_ok && !pad_seen)) begin
              if (is_pad) begin
                nb = pad_seen ? 2'd1 : 2'd2;
              end
              push_next.push = 1'b1;
              push_next.cmd.is_status = b64d_pkg::KIND_DATA;
              push_next.cmd.status = b64d_pkg::STATUS_OK;
              push_next.cmd.nbytes = nb;
              push_next.cmd.word = {group_bits, (is_pad ? 6'd0 : sx[5:0])};
              sum = {1'b0, total} + (b64d_pkg::COUNT_BITS + 1)'(nb);
              total_next = sum[b64d_pkg::COUNT_BITS] ? b64d_pkg::COUNT_MAX
                                                     : sum[b64d_pkg::COUNT_BITS-1:0];
              group_bits_next = '0;
              group_pos_next = '0;
              pad_seen_next = 1'b0;
            end else begin
              failed_next = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits <= '0;
      group_pos <= '0;
      pad_seen <= 1'b0;
      stopped <= 1'b0;
      failed <= 1'b0;
      total <= '0;
    end else begin
      group_bits <= group_bits_next;
      group_pos <= group_pos_next;
      pad_seen <= pad_seen_next;
      stopped <= stopped_next;
      failed <= failed_next;
      total <= total_next;
    end
  end

  assign push_out = push_next;

endmodule

FILE: src/b64d_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module b64d_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  b64d_pkg::b64d_push_t push_in,
  input  logic                 pop,
  output logic                 full,
  output b64d_pkg::b64d_head_t head
);

  b64d_pkg::b64d_cmd_t         slots [b64d_pkg::QUEUE_DEPTH];
  logic [b64d_pkg::QPTR_W-1:0] wr_ptr;
  logic [b64d_pkg::QPTR_W-1:0] rd_ptr;
  logic [b64d_pkg::QPTR_W:0]   count;
  logic                        do_pop;

  assign full = (count == (b64d_pkg::QPTR_W + 1)'(b64d_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd = slots[rd_ptr];
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      slots[wr_ptr] <= push_in.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_in.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push_in.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (b64d_pkg::QPTR_W + 1)'(b64d_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push_in.push && full))
    else $error("push into full queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_in.push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

FILE: src/b64d_back.sv
// Back part: expands queued commands into result transfers through an output register.
`timescale 1ns / 1ps
module b64d_back (
  input  logic                                clk,
  input  logic                                rst,
  input  b64d_pkg::b64d_head_t                head,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [b64d_pkg::TDATA_OUT_W-1:0]    m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  logic [1:0] beat;
  logic       load;
  logic       last_beat;
  logic [7:0] sel_byte;

  assign load = head.valid && (!m_tvalid || m_tready);
  assign last_beat = head.cmd.is_status || (beat == head.cmd.nbytes - 2'd1);
  assign pop = load && last_beat;

  always_comb begin
    case (beat)
      2'd0:    sel_byte = head.cmd.word[23:16];
      2'd1:    sel_byte = head.cmd.word[15:8];
      default: sel_byte = head.cmd.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      beat <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        beat <= last_beat ? 2'd0 : beat + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tlast <= last_beat;
      m_tuser <= head.cmd.is_status;
      if (head.cmd.is_status) begin
        m_tdata <= {7'd0, head.cmd.word, head.cmd.status, 8'd0};
      end else begin
        m_tdata <= {7'd0, 24'd0, b64d_pkg::STATUS_OK, sel_byte};
      end
    end
  end

  a_beat_bound: assert property (@(posedge clk) disable iff (rst)
    beat <= 2'd2)
    else $error("beat index beyond three bytes");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (head.valid && head.cmd.is_status) |-> (beat == 2'd0))
    else $error("status command started mid-group");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (m_tvalid && m_tlast))
    else $error("command released without final transfer");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the base64 stream decoder: predicted results against the stream.
`timescale 1ns / 1ps
module tb_top;

  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 460;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [7:0]                         data;
    logic                               kind;
    logic                               status;
    logic [b64d_pkg::COUNT_FIELD_W-1:0] count;
    logic                               last;
  } result_t;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [b64d_pkg::TDATA_IN_W-1:0]  s_tdata;   // [7:0] ch
  logic                             s_tlast;   // is_end
  logic                             m_tvalid;
  logic                             m_tready;
  logic [b64d_pkg::TDATA_OUT_W-1:0] m_tdata;   // [7:0] out_byte, [8] status,
                                               // [32:9] byte_count, [39:33] zero
  logic                             m_tuser;   // kind
  logic                             m_tlast;   // run_last

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  result_t                          pending_results[$];
  logic [7:0]                       text_buf[$];
  logic [17:0]                      grp_bits;
  logic [1:0]                       grp_pos;
  logic [1:0]                       grp_pads;
  logic                             quiet_stop;
  logic                             bad_input;
  logic [b64d_pkg::COUNT_BITS-1:0]  byte_total;
  int                               live_items;
  int                               errors;
  int                               idle_count;
  int                               hold_len;
  logic                             tx_idle;
  logic                             rx_idle;

  base64_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int char_value(input logic [7:0] c);
    int i;
    for (i = 0; i < 64; i++) begin
      if (alphabet[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void clear_text_state();
    grp_bits = '0;
    grp_pos = '0;
    grp_pads = '0;
    quiet_stop = 1'b0;
    bad_input = 1'b0;
    byte_total = '0;
  endfunction

  function automatic void decode_item(input logic [7:0] c, input logic e);
    result_t     r;
    logic [23:0] word;
    int          v;
    int          n;
    int          k;
    int          npads;
    if (e) begin
      r.data = 8'h00;
      r.kind = b64d_pkg::KIND_STATUS;
      r.status = (bad_input || grp_pos != 0) ? b64d_pkg::STATUS_ERROR : b64d_pkg::STATUS_OK;
      r.count = b64d_pkg::COUNT_FIELD_W'(byte_total);
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_text_state();
      return;
    end
    if (quiet_stop || bad_input) begin
      return;
    end
    v = char_value(c);
    case (grp_pos)
      2'd0: begin
        if (v >= 0) begin
          grp_bits = 18'(v);
          grp_pads = '0;
          grp_pos = 2'd1;
        end else if (c == b64d_pkg::PAD_CHAR) begin
          bad_input = 1'b1;
        end else begin
          quiet_stop = 1'b1;
        end
      end
      2'd1: begin
        if (v >= 0) begin
          grp_bits = {grp_bits[11:0], 6'(v)};
          grp_pos = 2'd2;
        end else begin
          bad_input = 1'b1;
        end
      end
      2'd2: begin
        if (c == b64d_pkg::PAD_CHAR) begin
          grp_pads = 2'd1;
          grp_bits = {grp_bits[11:0], 6'd0};
          grp_pos = 2'd3;
        end else if (v >= 0) begin
          grp_bits = {grp_bits[11:0], 6'(v)};
          grp_pos = 2'd3;
        end else begin
          bad_input = 1'b1;
        end
      end
      default: begin
        if (c == b64d_pkg::PAD_CHAR) begin
          npads = int'(grp_pads) + 1;
          word = {grp_bits, 6'd0};
        end else if (v >= 0 && grp_pads == 0) begin
          npads = 0;
          word = {grp_bits, 6'(v)};
        end else begin
          bad_input = 1'b1;
          return;
        end
        n = 3 - npads;
        for (k = 0; k < n; k++) begin
          r.data = word[23 - 8 * k -: 8];
          r.kind = b64d_pkg::KIND_DATA;
          r.status = b64d_pkg::STATUS_OK;
          r.count = '0;
          r.last = (k == n - 1);
          pending_results.push_back(r);
          if (byte_total != b64d_pkg::COUNT_MAX) begin
            byte_total = byte_total + 1'b1;
          end
        end
        grp_bits = '0;
        grp_pos = '0;
        grp_pads = '0;
      end
    endcase
  endfunction

  task automatic send_item(input logic [7:0] c, input logic e);
    int   n;
    logic took;
    n = tx_idle ? $urandom_range(0, 13) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= e;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = s_tready;
      if (took) begin
        decode_item(c, e);
        live_items++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_text(input string txt, input logic [7:0] end_ch);
    int i;
    for (i = 0; i < txt.len(); i++) begin
      send_item(txt[i], 1'b0);
    end
    send_item(end_ch, 1'b1);
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < text_buf.size(); i++) begin
      send_item(text_buf[i], 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] foreign_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (char_value(c) >= 0 || c == b64d_pkg::PAD_CHAR);
    return c;
  endfunction

  // Groups with random content, all well-formed when clean; else mostly well-formed, some corrupted, cut or pure noise.
  task automatic make_text(input logic clean);
    int groups;
    int pads;
    int mode;
    int g;
    int i;
    int sz;
    text_buf.delete();
    groups = $urandom_range(1, 4);
    for (g = 0; g < groups; g++) begin
      for (i = 0; i < 4; i++) begin
        text_buf.push_back(alphabet[$urandom_range(0, 63)]);
      end
      pads = $urandom_range(0, 5);
      sz = text_buf.size();
      if (pads == 1) begin
        text_buf[sz - 1] = b64d_pkg::PAD_CHAR;
      end else if (pads == 2) begin
        text_buf[sz - 1] = b64d_pkg::PAD_CHAR;
        text_buf[sz - 2] = b64d_pkg::PAD_CHAR;
      end
    end
    mode = clean ? 99 : $urandom_range(0, 11);
    sz = text_buf.size();
    case (mode)
      0: text_buf[$urandom_range(0, sz - 1)] = 8'($urandom_range(0, 255));
      1: text_buf[$urandom_range(0, sz - 1)] = b64d_pkg::PAD_CHAR;
      2: repeat ($urandom_range(1, 3)) void'(text_buf.pop_back());
      3: begin
        text_buf.push_back(foreign_char());
        repeat ($urandom_range(0, 5)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        text_buf.delete();
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  task automatic test_known_vectors();
    send_text("/+9zTQ==TWE=", 8'h00);
    send_text("AB=C", 8'hFF);
    send_text("=", 8'h5A);
    send_text("A=", b64d_pkg::PAD_CHAR);
    send_item("A", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    send_text("AB", 8'h7F);
    send_item(8'h00, 1'b0);
    send_item("A", 1'b0);
    send_item(8'h01, 1'b1);
  endtask

  task automatic test_output_stall();
    tx_idle = 1'b0;
    hold_len = STALL_CYCLES;
    repeat (3) begin
      make_text(1'b1);
      send_buffer();
    end
    tx_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    make_text(1'b1);
    send_buffer();
    wait_drained();
    make_text(1'b1);
    send_buffer();
  endtask

  task automatic test_random_texts();
    int target;
    target = RANDOM_ITEMS;
    while (live_items < target) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      make_text(1'b0);
      send_buffer();
      if ($urandom_range(0, 15) == 0) begin
        wait_drained();
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : rx_proc
    int   n;
    logic took;
    m_tready <= 1'b0;
    do @(negedge clk); while (rst);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      n = rx_idle ? $urandom_range(0, 13) : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(negedge clk);
        took = m_tvalid;
        @(posedge clk);
      end while (!took && hold_len == 0);
    end
  end

  always @(negedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.data) begin
          $error("out_byte: expected %0h, actual %0h", want.data, m_tdata[7:0]);
          errors++;
        end
        if (m_tuser !== want.kind) begin
          $error("kind: expected %0b, actual %0b", want.kind, m_tuser);
          errors++;
        end
        if (m_tdata[8] !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, m_tdata[8]);
          errors++;
        end
        if (m_tdata[32:9] !== want.count) begin
          $error("byte_count: expected %0d, actual %0d", want.count, m_tdata[32:9]);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("run_last: expected %0b, actual %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    errors = 0;
    idle_count = 0;
    hold_len = 0;
    live_items = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    clear_text_state();
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_known_vectors();
    test_output_stall();
    test_sender_pause();
    test_random_texts();
    wait_drained();
    if (pending_results.size() != 0) begin
      $error("results still pending: %0d", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
